FILE: design/kcgc_pkg.sv
// Shared types and constants for the keypad click and long-press classifier.
package kcgc_pkg;

  // Field widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned KeyW      = 5;
  localparam int unsigned EventW    = 2;
  localparam int unsigned ScanW     = 8;
  localparam int unsigned WindowW   = 10;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutDataW  = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCAN_PERIOD  = 2'd0,
    CFG_CLICK_WINDOW = 2'd1,
    CFG_LONG_HOLD    = 2'd2,
    CFG_LONG_REPEAT  = 2'd3
  } cfg_idx_t;

  // Click event codes
  typedef enum logic [EventW-1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } click_ev_t;

  // Reset values of the configuration registers
  localparam logic [ScanW-1:0]   ScanPeriodRst  = 8'd10;
  localparam logic [WindowW-1:0] ClickWindowRst = 10'd200;
  localparam logic [HoldW-1:0]   LongHoldRst    = 16'd1000;

  localparam logic [HoldW-1:0]   HoldMax        = 16'hFFFF;
  localparam logic [1:0]         ClickCountMax  = 2'd3;

  // One result word
  typedef struct packed {
    logic [KeyW-1:0]   long_key;
    logic              long_event;
    logic [KeyW-1:0]   click_key;
    logic [EventW-1:0] click_event;
  } result_t;

endpackage

FILE: design/kcgc_decode.sv
// Key matrix decoder: one active-low bit gives key row*4+col+1, else 0.
module kcgc_decode (
  input  logic [kcgc_pkg::SampleW-1:0] sample,
  output logic [kcgc_pkg::KeyW-1:0]    key
);
  import kcgc_pkg::*;

  logic [SampleW-1:0] low;
  logic               single_low;

  assign low        = ~sample;
  assign single_low = (low != '0) && ((low & (low - 1'b1)) == '0);

  // Bit b sits in column 3-(b/4), row b%4; only one bit can match
  always_comb begin
    key = '0;
    for (int b = 0; b < SampleW; b++) begin
      if (single_low && low[b]) begin
        key = KeyW'((b % 4) * 4 + (3 - b / 4) + 1);
      end
    end
  end

endmodule

FILE: design/keypad_click_gesture_classifier.sv
// Top level: keypad click (single/double) and long-press classifier.
//
//  channel | handshake             | word
//  --------+-----------------------+---------------------------------------------
//  in      | in_tvalid/in_tready   | one 1 ms tick: matrix sample
//  out     | out_tvalid/out_tready | one result per tick: click and long events
//  cfg     | cfg_we                | register write, index cfg_index
//
// One word per cycle: decode, click window and hold counters update in the
// cycle a word is accepted and the result lands in the output register.
// in_tready stays high while the output register is empty or being drained,
// so a stalled output holds one result and blocks only the next word.
// rst_n (synchronous) clears all counters and loads the register defaults.
module keypad_click_gesture_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kcgc_pkg::SampleW-1:0]     in_tdata,   // [15:0] matrix_sample
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] click_event, [6:2] click_key, [7] long_event, [12:8] long_key, [15:13] zero
  output logic [kcgc_pkg::OutDataW-1:0]    out_tdata,
  input  logic                             cfg_we,
  input  logic [kcgc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [kcgc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import kcgc_pkg::*;

  // Configuration registers
  logic [ScanW-1:0]   scan_period_r;
  logic [WindowW-1:0] click_window_r;
  logic [HoldW-1:0]   long_hold_r;
  logic               long_repeat_r;

  // Tick state
  logic [ScanW-1:0]   scan_div_r,    scan_div_nxt;
  logic [KeyW-1:0]    key_now_r,     key_now_nxt;
  logic               win_busy_r,    win_busy_nxt;
  logic [WindowW-1:0] win_ticks_r,   win_ticks_nxt;
  logic [1:0]         click_cnt_r,   click_cnt_nxt;
  logic [KeyW-1:0]    latched_key_r, latched_key_nxt;
  logic [HoldW-1:0]   hold_ticks_r,  hold_ticks_nxt;
  logic               long_lat_r,    long_lat_nxt;

  // Output stage
  logic               out_valid_r;
  result_t            res_r, res_nxt;

  logic               in_fire;
  logic [KeyW-1:0]    key_dec;
  logic [ScanW-1:0]   scan_inc;
  logic [WindowW-1:0] win_inc;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(res_r);

  kcgc_decode u_decode (
    .sample (in_tdata),
    .key    (key_dec)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r  <= ScanPeriodRst;
      click_window_r <= ClickWindowRst;
      long_hold_r    <= LongHoldRst;
      long_repeat_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCAN_PERIOD:  scan_period_r  <= cfg_wdata[ScanW-1:0];
        CFG_CLICK_WINDOW: click_window_r <= cfg_wdata[WindowW-1:0];
        CFG_LONG_HOLD:    long_hold_r    <= cfg_wdata[HoldW-1:0];
        CFG_LONG_REPEAT:  long_repeat_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Per-tick update: scan/decode, click window, long press
  always_comb begin
    scan_div_nxt    = scan_div_r;
    key_now_nxt     = key_now_r;
    win_busy_nxt    = win_busy_r;
    win_ticks_nxt   = win_ticks_r;
    click_cnt_nxt   = click_cnt_r;
    latched_key_nxt = latched_key_r;
    hold_ticks_nxt  = hold_ticks_r;
    long_lat_nxt    = long_lat_r;
    res_nxt         = '0;

    // scan divider and decode
    scan_inc     = scan_div_r + 1'b1;
    scan_div_nxt = scan_inc;
    if (scan_inc == scan_period_r) begin
      scan_div_nxt = '0;
      key_now_nxt  = key_dec;
      if (key_now_r < key_dec) begin
        if (!win_busy_r) begin
          win_busy_nxt    = 1'b1;
          latched_key_nxt = key_dec;
        end
        if (click_cnt_r != ClickCountMax) begin
          click_cnt_nxt = click_cnt_r + 1'b1;
        end
      end
      if (key_now_r > key_dec) begin
        long_lat_nxt = 1'b0;
      end
    end

    // click window
    win_inc = win_ticks_r + 1'b1;
    if (win_busy_nxt) begin
      win_ticks_nxt = win_inc;
      if (win_inc == click_window_r) begin
        win_ticks_nxt = '0;
        if (click_cnt_nxt == 2'd1 || click_cnt_nxt == 2'd2) begin
          res_nxt.click_event = click_cnt_nxt;
          res_nxt.click_key   = latched_key_nxt;
        end
        win_busy_nxt  = 1'b0;
        click_cnt_nxt = '0;
      end
    end

    // long press
    if (key_now_nxt != '0) begin
      if (hold_ticks_r != HoldMax) begin
        hold_ticks_nxt = hold_ticks_r + 1'b1;
      end
      if (hold_ticks_nxt > long_hold_r && !long_lat_nxt) begin
        res_nxt.long_event = 1'b1;
        res_nxt.long_key   = key_now_nxt;
        if (!long_repeat_r) begin
          long_lat_nxt = 1'b1;
        end
      end
    end else begin
      hold_ticks_nxt = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_div_r    <= '0;
      key_now_r     <= '0;
      win_busy_r    <= 1'b0;
      win_ticks_r   <= '0;
      click_cnt_r   <= '0;
      latched_key_r <= '0;
      hold_ticks_r  <= '0;
      long_lat_r    <= 1'b0;
    end else if (in_fire) begin
      scan_div_r    <= scan_div_nxt;
      key_now_r     <= key_now_nxt;
      win_busy_r    <= win_busy_nxt;
      win_ticks_r   <= win_ticks_nxt;
      click_cnt_r   <= click_cnt_nxt;
      latched_key_r <= latched_key_nxt;
      hold_ticks_r  <= hold_ticks_nxt;
      long_lat_r    <= long_lat_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

endmodule
